// ===== hw/rtl/ghr_pkg.sv =====
// ----------------------------------------------------------------------------
// ghr_pkg
// Shared types and constants of the generational handle registry.
// ----------------------------------------------------------------------------
package ghr_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned PIN_W  = 32;
  localparam int unsigned STAT_W = 3;

  localparam logic [GEN_W-1:0] GEN_MAX = '1;
  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  typedef enum logic [1:0] {
    ACT_PUBLISH = 2'd0,
    ACT_PIN     = 2'd1,
    ACT_UNPIN   = 2'd2,
    ACT_REVOKE  = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_STALE    = 3'd1,
    ST_REVOKED  = 3'd2,
    ST_PUBFAIL  = 3'd3,
    ST_PINLIMIT = 3'd4
  } status_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [ID_W-1:0]  identity;
    logic [GEN_W-1:0] generation;
    logic [PIN_W-1:0] pin_count;
    logic             withdrawn;
  } entry_t;

  // Results of the shared compare unit.
  typedef struct packed {
    logic id_eq;
    logic gen_eq;
    logic gen_gt;
  } cmp_res_t;

endpackage

// ===== hw/rtl/generational_handle_registry_core.sv =====
// ----------------------------------------------------------------------------
// generational_handle_registry_core
// Handle table with publish, pin, unpin and revoke commands.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_action, in_identity and in_generation while busy is
//   low; the command word is taken at that clock edge and busy rises.
//   Exactly one result word follows: out_valid is high for one cycle with
//   out_status, out_handle_identity and out_handle_generation. The receiver
//   cannot stall, so the result is simply shown for that cycle.
// Timing:
//   Entries are never freed, so the used entries are always 0..fill-1.
//   A command scans them one per cycle through the single read port and one
//   shared compare unit; a lookup stops at its first match. The next
//   command may be started in the cycle the strobe is high.
// Reset:
//   rst_n low (synchronous) empties the table by clearing the fill count;
//   no clearing pass over the memory is needed.
// ----------------------------------------------------------------------------
module generational_handle_registry_core #(
  parameter int unsigned TABLE_ENTRIES = ghr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [ghr_pkg::ID_W-1:0]     in_identity,
  input  logic [ghr_pkg::GEN_W-1:0]    in_generation,
  output logic                         out_valid,
  output logic [ghr_pkg::STAT_W-1:0]   out_status,
  output logic [ghr_pkg::ID_W-1:0]     out_handle_identity,
  output logic [ghr_pkg::GEN_W-1:0]    out_handle_generation
);
  import ghr_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  // Sequencer state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pend_idx_r, pend_idx_nxt;

  // Latched command word
  action_t         act_r, act_nxt;
  logic [ID_W-1:0] cid_r, cid_nxt;
  logic [GEN_W-1:0] cgen_r, cgen_nxt;

  // Scan results
  logic [GEN_W-1:0] maxg_r, maxg_nxt;
  logic            found_r, found_nxt;
  logic [AW-1:0]   fidx_r, fidx_nxt;
  logic [PIN_W-1:0] fpin_r, fpin_nxt;
  logic            fwd_r, fwd_nxt;

  // Result word
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  logic [GEN_W-1:0] out_gen_r, out_gen_nxt;

  // Table ports
  logic            tbl_we, tbl_re;
  logic [AW-1:0]   tbl_waddr, tbl_raddr;
  entry_t          tbl_wdata, tbl_rdata;
  cmp_res_t        cmp;

  logic            issue, hit_now;

  ghr_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  ghr_cmp u_cmp (
    .ent            (tbl_rdata),
    .cmd_identity   (cid_r),
    .cmd_generation (cgen_r),
    .max_generation (maxg_r),
    .res            (cmp)
  );

  assign busy = (state_r != S_IDLE);

  // Issue the next read while used entries remain; a lookup hit ends the
  // scan at the lowest matching entry.
  assign issue   = (idx_r < fill_r);
  assign hit_now = pend_r && (act_r != ACT_PUBLISH) && cmp.id_eq && cmp.gen_eq;
  assign tbl_re    = (state_r == S_SCAN) && issue && !hit_now;
  assign tbl_raddr = idx_r[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    act_nxt        = act_r;
    cid_nxt        = cid_r;
    cgen_nxt       = cgen_r;
    maxg_nxt       = maxg_r;
    found_nxt      = found_r;
    fidx_nxt       = fidx_r;
    fpin_nxt       = fpin_r;
    fwd_nxt        = fwd_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_gen_nxt    = out_gen_r;
    tbl_we         = 1'b0;
    tbl_waddr      = fidx_r;
    tbl_wdata      = '{identity: cid_r, generation: cgen_r,
                       pin_count: fpin_r, withdrawn: fwd_r};

    case (state_r)
      S_IDLE: begin
        // Take a command word and clear the scan results.
        if (start) begin
          act_nxt   = action_t'(in_action);
          cid_nxt   = in_identity;
          cgen_nxt  = in_generation;
          maxg_nxt  = '0;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (tbl_re) begin
          idx_nxt      = idx_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
        end
        // Track the greatest generation held for the identity.
        if (pend_r && (act_r == ACT_PUBLISH) && cmp.id_eq && cmp.gen_gt) begin
          maxg_nxt = tbl_rdata.generation;
        end
        if (hit_now) begin
          found_nxt = 1'b1;
          fidx_nxt  = pend_idx_r;
          fpin_nxt  = tbl_rdata.pin_count;
          fwd_nxt   = tbl_rdata.withdrawn;
          pend_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else if (!issue && !pend_r) begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_id_nxt     = '0;
        out_gen_nxt    = '0;
        case (act_r)
          ACT_PUBLISH: begin
            if ((cid_r == '0) || (fill_r == FULL_CNT) || (maxg_r == GEN_MAX)) begin
              out_status_nxt = ST_PUBFAIL;
            end else begin
              tbl_we      = 1'b1;
              tbl_waddr   = fill_r[AW-1:0];
              tbl_wdata   = '{identity: cid_r, generation: maxg_r + GEN_W'(1),
                              pin_count: '0, withdrawn: 1'b0};
              fill_nxt    = fill_r + CW'(1);
              out_id_nxt  = cid_r;
              out_gen_nxt = maxg_r + GEN_W'(1);
            end
          end
          ACT_PIN: begin
            if (!found_r) begin
              out_status_nxt = ST_STALE;
            end else if (fwd_r) begin
              out_status_nxt = ST_REVOKED;
            end else if (fpin_r == PIN_MAX) begin
              out_status_nxt = ST_PINLIMIT;
            end else begin
              tbl_we              = 1'b1;
              tbl_wdata.pin_count = fpin_r + PIN_W'(1);
            end
          end
          ACT_UNPIN: begin
            if (!found_r || (fpin_r == '0)) begin
              out_status_nxt = ST_STALE;
            end else begin
              tbl_we              = 1'b1;
              tbl_wdata.pin_count = fpin_r - PIN_W'(1);
            end
          end
          default: begin
            // Revoke: mark the entry; a second revoke leaves it as is.
            if (!found_r) begin
              out_status_nxt = ST_STALE;
            end else begin
              tbl_we              = 1'b1;
              tbl_wdata.withdrawn = 1'b1;
            end
          end
        endcase
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    act_r        <= act_nxt;
    cid_r        <= cid_nxt;
    cgen_r       <= cgen_nxt;
    maxg_r       <= maxg_nxt;
    fidx_r       <= fidx_nxt;
    fpin_r       <= fpin_nxt;
    fwd_r        <= fwd_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_gen_r    <= out_gen_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handle_identity   = out_id_r;
  assign out_handle_generation = out_gen_r;

`ifndef SYNTH
  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond table size");

  // A result word follows only the finishing step of a command.
  a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_FINISH))
    else $error("result without finished command");

  // The table is written only while a command finishes.
  a_write_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (state_r == S_FINISH))
    else $error("table write outside finish step");

  // A successful publish grows the table by exactly one entry.
  a_publish_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_id_r != '0)) |-> (fill_r == $past(fill_r) + CW'(1)))
    else $error("publish did not claim one entry");
`endif

endmodule

// ===== hw/rtl/ghr_table.sv =====
// ----------------------------------------------------------------------------
// ghr_table
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ghr_table #(
  parameter int unsigned TABLE_ENTRIES = ghr_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ghr_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output ghr_pkg::entry_t rdata
);
  import ghr_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ghr_cmp.sv =====
// ----------------------------------------------------------------------------
// ghr_cmp
// Shared compare unit: tests one entry against the command and the best
// generation seen so far.
// ----------------------------------------------------------------------------
module ghr_cmp (
  input  ghr_pkg::entry_t             ent,
  input  logic [ghr_pkg::ID_W-1:0]    cmd_identity,
  input  logic [ghr_pkg::GEN_W-1:0]   cmd_generation,
  input  logic [ghr_pkg::GEN_W-1:0]   max_generation,
  output ghr_pkg::cmp_res_t           res
);
  import ghr_pkg::*;

  always_comb begin
    res.id_eq  = (ent.identity == cmd_identity);
    res.gen_eq = (ent.generation == cmd_generation);
    res.gen_gt = (ent.generation > max_generation);
  end

endmodule

// ===== tb/tb_generational_handle_registry_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_generational_handle_registry_core
// Self-checking bench for the handle registry: publish, pin, unpin, revoke.
// A tracker class keeps its own copy of the handle table, works out the
// reply word of every accepted command and compares each strobed reply
// against the oldest outstanding one. Stimulus is a directed opener, then
// random traffic aimed mostly at live handles, then a burst that fills the
// table.
// ----------------------------------------------------------------------------
module tb_generational_handle_registry_core;
  import ghr_pkg::*;

  typedef struct {
    status_t          status;
    logic [ID_W-1:0]  handle_id;
    logic [GEN_W-1:0] handle_gen;
  } reply_t;

  class registry_tracker;
    localparam int unsigned N = TABLE_ENTRIES_DEF;

    // Entries are never freed, so the live entries are always 0..fill_count-1.
    logic [ID_W-1:0]  held_id      [N];
    logic [GEN_W-1:0] held_gen     [N];
    logic [PIN_W-1:0] held_pins    [N];
    bit               held_revoked [N];
    int unsigned      fill_count;

    reply_t      pending_replies[$];
    int unsigned mismatches;
    int unsigned replies_checked;
    int unsigned status_seen[8];

    function void note_command(action_t act, logic [ID_W-1:0] id,
                               logic [GEN_W-1:0] gen);
      reply_t           r;
      int               hit;
      logic [GEN_W-1:0] top_gen;
      r.status     = ST_OK;
      r.handle_id  = '0;
      r.handle_gen = '0;
      if (act == ACT_PUBLISH) begin
        top_gen = '0;
        for (int i = 0; i < int'(fill_count); i++) begin
          if (held_id[i] == id && held_gen[i] > top_gen) top_gen = held_gen[i];
        end
        if (id == '0 || fill_count == N || top_gen == GEN_MAX) begin
          r.status = ST_PUBFAIL;
        end else begin
          held_id[fill_count]      = id;
          held_gen[fill_count]     = top_gen + GEN_W'(1);
          held_pins[fill_count]    = '0;
          held_revoked[fill_count] = 1'b0;
          fill_count++;
          r.handle_id  = id;
          r.handle_gen = top_gen + GEN_W'(1);
        end
      end else begin
        hit = -1;
        for (int i = 0; i < int'(fill_count); i++) begin
          if (hit < 0 && held_id[i] == id && held_gen[i] == gen) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_STALE;
        end else begin
          case (act)
            ACT_PIN: begin
              if (held_revoked[hit]) r.status = ST_REVOKED;
              else if (held_pins[hit] == PIN_MAX) r.status = ST_PINLIMIT;
              else held_pins[hit]++;
            end
            ACT_UNPIN: begin
              if (held_pins[hit] == '0) r.status = ST_STALE;
              else held_pins[hit]--;
            end
            default: begin
              held_revoked[hit] = 1'b1;
            end
          endcase
        end
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [STAT_W-1:0] st, logic [ID_W-1:0] hid,
                              logic [GEN_W-1:0] hgen);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply word: status %0d id %h gen %h",
                 $time, st, hid, hgen);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, st);
        mismatches++;
      end
      if (hid !== want.handle_id) begin
        $display("%0t: handle identity mismatch: expected %h, got %h",
                 $time, want.handle_id, hid);
        mismatches++;
      end
      if (hgen !== want.handle_gen) begin
        $display("%0t: handle generation mismatch: expected %h, got %h",
                 $time, want.handle_gen, hgen);
        mismatches++;
      end
      if (!$isunknown(st)) status_seen[st]++;
    endfunction
  endclass

  localparam int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int unsigned RANDOM_WORDS  = 1200;
  localparam int unsigned FILL_WORDS    = 90;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             start         = 1'b0;
  logic [1:0]       in_action     = ACT_PUBLISH;
  logic [ID_W-1:0]  in_identity   = '0;
  logic [GEN_W-1:0] in_generation = '0;
  logic             busy;
  logic             out_valid;
  logic [STAT_W-1:0] out_status;
  logic [ID_W-1:0]  out_handle_identity;
  logic [GEN_W-1:0] out_handle_generation;

  registry_tracker tracker = new();

  // A handful of identities that get published again and again, so that
  // generations climb past one; all-ones and one are the field extremes.
  logic [ID_W-1:0] id_pool[6];
  int unsigned     words_sent;

  generational_handle_registry_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_action             (in_action),
    .in_identity           (in_identity),
    .in_generation         (in_generation),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_handle_identity   (out_handle_identity),
    .out_handle_generation (out_handle_generation)
  );

  always #6 clk = ~clk;

  // Reply side: the block cannot be stalled, so every strobe is one word,
  // sampled with the values it held during the cycle that this edge ends.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      tracker.check_reply(out_status, out_handle_identity, out_handle_generation);
    end
  end

  // Offer one command word and hold it until the block takes it. Call at a
  // rising edge; a zero gap keeps start high straight into the next word.
  task automatic send_command(input action_t act, input logic [ID_W-1:0] id,
                              input logic [GEN_W-1:0] gen, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_action     <= act;
    in_identity   <= id;
    in_generation <= gen;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_command(act, id, gen);
    words_sent++;
  endtask

  // Build one random command. Most pin, unpin and revoke words address a
  // live handle; the rest are near misses and plain noise.
  task automatic pick_command(output action_t act, output logic [ID_W-1:0] id,
                              output logic [GEN_W-1:0] gen);
    int unsigned roll;
    int unsigned k;
    roll = $urandom_range(0, 99);
    gen  = $urandom();
    if (roll < 5) begin
      act  = ACT_PUBLISH;
      roll = $urandom_range(0, 99);
      if (roll < 80) id = id_pool[$urandom_range(0, 5)];
      else if (roll < 95) id = $urandom();
      else id = '0;
      return;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) act = ACT_PIN;
    else if (roll < 92) act = ACT_UNPIN;
    else act = ACT_REVOKE;
    roll = $urandom_range(0, 99);
    if (tracker.fill_count != 0 && roll < 80) begin
      k   = $urandom_range(0, tracker.fill_count - 1);
      id  = tracker.held_id[k];
      gen = tracker.held_gen[k];
    end else if (tracker.fill_count != 0 && roll < 90) begin
      // Right identity, wrong generation: one past, zero, or all ones.
      k  = $urandom_range(0, tracker.fill_count - 1);
      id = tracker.held_id[k];
      case ($urandom_range(0, 2))
        0:       gen = tracker.held_gen[k] + GEN_W'(1);
        1:       gen = '0;
        default: gen = GEN_MAX;
      endcase
    end else if (roll < 95) begin
      id = $urandom();
    end else begin
      id  = '0;
      gen = $urandom_range(0, 3);
    end
  endtask

  // Generation exhaustion and pin saturation need on the order of 2**32
  // commands on one identity or entry, far beyond any run; the tracker still
  // models both, but no stimulus can reach them.
  initial begin : stimulus
    action_t          act;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    logic [ID_W-1:0]  stray_id;
    bit               idling;
    int unsigned      gap;

    id_pool[0] = 32'h0000_0001;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) begin
      id_pool[i] = $urandom();
      if (id_pool[i] == '0) id_pool[i] = 32'h0000_0002;
    end
    stray_id = $urandom() | 32'h0001_0000;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opener: rejected publishes, generations climbing, the pin
    // count walking up and back to zero, misses, and revoked handles.
    send_command(ACT_PUBLISH, '0, '0, 0);
    send_command(ACT_PIN, '0, '0, 0);
    send_command(ACT_PUBLISH, 32'hFFFF_FFFF, '0, 0);
    send_command(ACT_PUBLISH, 32'hFFFF_FFFF, GEN_MAX, 0);
    send_command(ACT_PUBLISH, 32'h0000_0001, '0, 0);
    send_command(ACT_PIN, 32'hFFFF_FFFF, 32'd1, 0);
    send_command(ACT_PIN, 32'hFFFF_FFFF, 32'd1, 0);
    send_command(ACT_UNPIN, 32'hFFFF_FFFF, 32'd1, 0);
    send_command(ACT_UNPIN, 32'hFFFF_FFFF, 32'd1, 0);
    send_command(ACT_UNPIN, 32'hFFFF_FFFF, 32'd1, 0);
    send_command(ACT_PIN, 32'hFFFF_FFFF, 32'd3, 0);
    send_command(ACT_PIN, 32'hFFFF_FFFF, 32'd0, 0);
    send_command(ACT_PIN, 32'hFFFF_FFFF, GEN_MAX, 0);
    send_command(ACT_REVOKE, 32'h0000_0001, 32'd1, 0);
    send_command(ACT_REVOKE, 32'h0000_0001, 32'd1, 0);
    send_command(ACT_PIN, 32'h0000_0001, 32'd1, 0);
    send_command(ACT_UNPIN, 32'h0000_0001, 32'd1, 0);
    send_command(ACT_PIN, 32'hFFFF_FFFF, 32'd2, 0);
    send_command(ACT_REVOKE, 32'hFFFF_FFFF, 32'd2, 0);
    send_command(ACT_UNPIN, 32'hFFFF_FFFF, 32'd2, 0);
    send_command(ACT_REVOKE, stray_id, 32'd1, 0);
    send_command(ACT_UNPIN, stray_id, 32'd1, 0);
    send_command(ACT_PUBLISH, 32'h8000_0000, '0, 0);
    send_command(ACT_PUBLISH, 32'h0000_0001, '0, 0);

    // Random traffic; idling switches on and off in stretches of 50 words.
    idling = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) idling = ($urandom_range(0, 3) != 0);
      gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      pick_command(act, id, gen);
      send_command(act, id, gen, gap);
    end

    // Closing burst, back to back: publish until the table is full and then
    // some, with live-handle traffic mixed in.
    for (int n = 0; n < FILL_WORDS; n++) begin
      if (n % 4 == 3) begin
        pick_command(act, id, gen);
        send_command(act, id, gen, 0);
      end else begin
        send_command(ACT_PUBLISH, id_pool[$urandom_range(0, 5)], $urandom(), 0);
      end
    end
    start <= 1'b0;

    // Drain, then give a late stray strobe one full scan to show up.
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    $display("Sent %0d command words, checked %0d replies; table filled to %0d of %0d.",
             words_sent, tracker.replies_checked, tracker.fill_count, TABLE_ENTRIES);
    $display("Replies by status: ok %0d, stale %0d, revoked %0d, publish failed %0d.",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_STALE],
             tracker.status_seen[ST_REVOKED], tracker.status_seen[ST_PUBFAIL]);
    if (tracker.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (every word a full scan).
  initial begin : watchdog
    #(64'd12 * 64'd500_000);
    $display("Timeout with %0d replies outstanding", tracker.pending_replies.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
